// ===== design/mfpr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfpr_pkg
// Shared types and codes for the marker framed packet receiver.
// ----------------------------------------------------------------------------
package mfpr_pkg;

    localparam int STATUS_W = 2;
    localparam int BYTE_W   = 8;

    localparam logic [STATUS_W-1:0] STATUS_PAYLOAD      = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DOUBLE_START = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY        = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW     = 2'd3;

    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    localparam logic [BYTE_W-1:0] START_MARKER_RST = 8'd60;
    localparam logic [BYTE_W-1:0] END_MARKER_RST   = 8'd62;

    typedef enum logic [1:0] {
        ST_WAIT,
        ST_READ,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic reading;
        logic draining;
    } t_ctrl_stat;

endpackage
`default_nettype wire

// ===== design/mfpr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfpr_ram
// Generic simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mfpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 63,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/mfpr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfpr_ctrl
// Deframing state machine, marker registers, buffer addressing and result
// register. Payload data of a drained frame comes straight from the RAM.
// ----------------------------------------------------------------------------
module mfpr_ctrl #(
    parameter int FRAME_BUFFER_BYTES = 64,
    localparam int DEPTH = FRAME_BUFFER_BYTES - 1,
    localparam int CW    = $clog2(FRAME_BUFFER_BYTES),
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_index,
    input  wire logic [mfpr_pkg::BYTE_W-1:0]         i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [mfpr_pkg::BYTE_W-1:0]         i_rx_byte,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic [mfpr_pkg::STATUS_W-1:0]            o_status,
    output logic                                     o_out_payload,
    output logic                                     o_last_of_run,
    output logic                                     o_mem_we,
    output logic [AW-1:0]                            o_mem_waddr,
    output logic [mfpr_pkg::BYTE_W-1:0]              o_mem_wdata,
    output logic                                     o_mem_re,
    output logic [AW-1:0]                            o_mem_raddr,
    output mfpr_pkg::t_ctrl_stat                     o_stat
);

    import mfpr_pkg::*;

    localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [AW-1:0]       r_rd_addr, n_rd_addr;
    logic [BYTE_W-1:0]   r_start, r_end;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic                r_out_last, n_out_last;

    logic slot_free;
    logic in_fire;
    logic is_start;
    logic is_end;
    logic rd_last;

    assign slot_free  = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state != ST_DRAIN) && slot_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign is_start   = (i_rx_byte == r_start);
    assign is_end     = (i_rx_byte == r_end);
    assign rd_last    = (CW'(r_rd_addr) == (r_cnt - CW'(1)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_MARKER_RST;
            r_end   <= END_MARKER_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_START_MARKER: r_start <= i_cfg_data;
                REG_END_MARKER:   r_end   <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_WAIT;
            r_cnt       <= '0;
            r_rd_addr   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_rd_addr   <= n_rd_addr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_rd_addr    = r_rd_addr;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        o_mem_we     = 1'b0;
        o_mem_re     = 1'b0;

        case (r_state)
            ST_WAIT: begin
                if (in_fire && is_start) begin
                    n_state = ST_READ;
                    n_cnt   = '0;
                end
            end
            ST_READ: begin
                if (in_fire) begin
                    if (is_start) begin
                        n_state      = ST_WAIT;
                        n_cnt        = '0;
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_DOUBLE_START;
                        n_out_last   = 1'b1;
                    end else if (is_end) begin
                        if (r_cnt == '0) begin
                            n_state      = ST_WAIT;
                            n_out_valid  = 1'b1;
                            n_out_status = STATUS_EMPTY;
                            n_out_last   = 1'b1;
                        end else begin
                            n_state   = ST_DRAIN;
                            n_rd_addr = '0;
                        end
                    end else if (r_cnt >= CNT_MAX) begin
                        n_state      = ST_WAIT;
                        n_cnt        = '0;
                        n_out_valid  = 1'b1;
                        n_out_status = STATUS_OVERFLOW;
                        n_out_last   = 1'b1;
                    end else begin
                        o_mem_we = 1'b1;
                        n_cnt    = r_cnt + CW'(1);
                    end
                end
            end
            ST_DRAIN: begin
                if (slot_free) begin
                    o_mem_re     = 1'b1;
                    n_out_valid  = 1'b1;
                    n_out_status = STATUS_PAYLOAD;
                    n_out_last   = rd_last;
                    n_rd_addr    = r_rd_addr + AW'(1);
                    if (rd_last) begin
                        n_state = ST_WAIT;
                        n_cnt   = '0;
                    end
                end
            end
            default: begin
                n_state = ST_WAIT;
                n_cnt   = '0;
            end
        endcase
    end

    assign o_mem_waddr   = r_cnt[AW-1:0];
    assign o_mem_wdata   = i_rx_byte;
    assign o_mem_raddr   = r_rd_addr;
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_out_payload = (r_out_status == STATUS_PAYLOAD);
    assign o_last_of_run = r_out_last;

    assign o_stat.reading  = (r_state == ST_READ);
    assign o_stat.draining = (r_state == ST_DRAIN);

endmodule
`default_nettype wire

// ===== design/marker_framed_packet_receiver_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// marker_framed_packet_receiver_top
// Deframes start/end marker bounded packets; payload is buffered in a RAM and
// replayed as a run of result transactions when the end marker arrives.
// ----------------------------------------------------------------------------
// Ordinary bytes are taken at one per cycle while the result slot is free;
// an error result is presented the cycle after its byte is accepted. An end
// marker after N stored bytes starts their drain, one RAM read per cycle while
// the slot is free; no byte is taken until the last payload byte is loaded.
// Synchronous active-low reset: waiting for start, markers at 60 and 62, no
// result pending. Buffer contents are not cleared.
// ----------------------------------------------------------------------------
module marker_framed_packet_receiver_top #(
    parameter int FRAME_BUFFER_BYTES = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_cfg_index,
    input  wire logic [mfpr_pkg::BYTE_W-1:0] i_cfg_data,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [mfpr_pkg::BYTE_W-1:0] i_rx_byte,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [mfpr_pkg::STATUS_W-1:0]    o_status,
    output logic [mfpr_pkg::BYTE_W-1:0]      o_data_byte,
    output logic                             o_last_of_run
);

    import mfpr_pkg::*;

    localparam int DEPTH = FRAME_BUFFER_BYTES - 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [BYTE_W-1:0] mem_wdata;
    logic              mem_re;
    logic [AW-1:0]     mem_raddr;
    logic [BYTE_W-1:0] mem_rdata;
    logic              out_payload;
    t_ctrl_stat        stat;

    mfpr_ctrl #(
        .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_rx_byte     (i_rx_byte),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_out_payload (out_payload),
        .o_last_of_run (o_last_of_run),
        .o_mem_we      (mem_we),
        .o_mem_waddr   (mem_waddr),
        .o_mem_wdata   (mem_wdata),
        .o_mem_re      (mem_re),
        .o_mem_raddr   (mem_raddr),
        .o_stat        (stat)
    );

    mfpr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_data_byte = out_payload ? mem_rdata : '0;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != STATUS_PAYLOAD) |-> (o_last_of_run && o_data_byte == '0))
        else $error("error transaction not flagged last or carries data");

    a_no_take_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.draining |-> !o_in_ready)
        else $error("input taken while draining");

    a_drain_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(stat.draining) |-> $past(stat.reading))
        else $error("drain entered outside a frame");

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_we && mem_re))
        else $error("buffer written during drain");

endmodule
`default_nettype wire

// ===== bench/marker_framed_packet_receiver_checker.sv =====
// ----------------------------------------------------------------------------
// marker_framed_packet_receiver_checker
// Watches the byte, result and register ports of the frame receiver, keeps
// its own copy of the deframing state and compares each result transaction
// with the oldest predicted one. Hands the mismatch count and the number of
// results still awaited to the testbench top.
// ----------------------------------------------------------------------------
module marker_framed_packet_receiver_checker #(
    parameter int FRAME_BUFFER_BYTES = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_index,
    input  logic [mfpr_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic [mfpr_pkg::BYTE_W-1:0] i_rx_byte,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic [mfpr_pkg::STATUS_W-1:0] i_status,
    input  logic [mfpr_pkg::BYTE_W-1:0] i_data_byte,
    input  logic                        i_last_of_run,
    output int                          o_fail_count,
    output int                          o_pending
);
    import mfpr_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data_byte;
        logic                last_of_run;
    } t_frame_result;

    t_frame_result     deframed_results[$];
    logic [BYTE_W-1:0] open_marker;
    logic [BYTE_W-1:0] close_marker;
    logic              frame_open;
    int                stored_count;
    logic [BYTE_W-1:0] stored_bytes [FRAME_BUFFER_BYTES];
    int                bad_result_count = 0;

    function automatic void abandon_frame(input logic [STATUS_W-1:0] code);
        t_frame_result r;
        r.status = code;
        r.data_byte = '0;
        r.last_of_run = 1'b1;
        deframed_results.push_back(r);
        frame_open = 1'b0;
        stored_count = 0;
    endfunction

    function automatic void deframe_byte(input logic [BYTE_W-1:0] b);
        t_frame_result r;
        if (!frame_open) begin
            if (b == open_marker)
                frame_open = 1'b1;
        end else if (b == open_marker) begin
            abandon_frame(STATUS_DOUBLE_START);
        end else if (b == close_marker) begin
            if (stored_count == 0) begin
                abandon_frame(STATUS_EMPTY);
            end else begin
                for (int k = 0; k < stored_count; k++) begin
                    r.status = STATUS_PAYLOAD;
                    r.data_byte = stored_bytes[k];
                    r.last_of_run = (k == stored_count - 1);
                    deframed_results.push_back(r);
                end
                frame_open = 1'b0;
                stored_count = 0;
            end
        end else if (stored_count + 1 >= FRAME_BUFFER_BYTES) begin
            abandon_frame(STATUS_OVERFLOW);
        end else begin
            stored_bytes[stored_count] = b;
            stored_count++;
        end
    endfunction

    function automatic void compare_result();
        t_frame_result want;
        if (deframed_results.size() == 0) begin
            if (bad_result_count < 10)
                $display("unexpected result: status %0d data %02h last %0b",
                         i_status, i_data_byte, i_last_of_run);
            bad_result_count++;
        end else begin
            want = deframed_results.pop_front();
            if (want.status !== i_status || want.data_byte !== i_data_byte
                    || want.last_of_run !== i_last_of_run) begin
                if (bad_result_count < 10)
                    $display({"mismatch: expected status %0d data %02h last %0b,",
                              " got status %0d data %02h last %0b"},
                             want.status, want.data_byte, want.last_of_run,
                             i_status, i_data_byte, i_last_of_run);
                bad_result_count++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            open_marker = START_MARKER_RST;
            close_marker = END_MARKER_RST;
            frame_open = 1'b0;
            stored_count = 0;
            deframed_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_START_MARKER)
                    open_marker = i_cfg_data;
                else if (i_cfg_index == REG_END_MARKER)
                    close_marker = i_cfg_data;
            end
            if (i_out_valid && i_out_ready)
                compare_result();
            if (i_in_valid && i_in_ready)
                deframe_byte(i_rx_byte);
        end
        o_fail_count <= bad_result_count;
        o_pending <= deframed_results.size();
    end

endmodule

// ===== bench/marker_framed_packet_receiver_top_test.sv =====
// ----------------------------------------------------------------------------
// marker_framed_packet_receiver_top_test
// Drives received bytes through the frame receiver under several marker
// settings: directed frames first, then random well-formed, broken and noisy
// traffic with bursty input and a stalling result port. The checker beside
// the block predicts every result transaction and counts mismatches.
// ----------------------------------------------------------------------------
module marker_framed_packet_receiver_top_test;
    import mfpr_pkg::*;

    localparam int FRAME_BUFFER_BYTES = 64;
    localparam int RESET_CYCLES = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int TIMEOUT_CYCLES = 200000;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic                i_cfg_index = REG_START_MARKER;
    logic [BYTE_W-1:0]   i_cfg_data = '0;
    logic                i_in_valid = 1'b0;
    logic [BYTE_W-1:0]   i_rx_byte = '0;
    logic                i_out_ready = 1'b0;
    logic                o_in_ready;
    logic                o_out_valid;
    logic [STATUS_W-1:0] o_status;
    logic [BYTE_W-1:0]   o_data_byte;
    logic                o_last_of_run;

    int fail_count;
    int pending_results;

    logic [BYTE_W-1:0] open_byte = START_MARKER_RST;
    logic [BYTE_W-1:0] close_byte = END_MARKER_RST;
    int                bytes_sent = 0;
    int                burst_left = 0;
    logic              hold_off_req = 1'b0;
    logic              hold_off_done = 1'b0;

    marker_framed_packet_receiver_top #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_rx_byte(i_rx_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_data_byte(o_data_byte),
        .o_last_of_run(o_last_of_run)
    );

    marker_framed_packet_receiver_checker #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) checker_i (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_in_ready(o_in_ready),
        .i_rx_byte(i_rx_byte),
        .i_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_status(o_status),
        .i_data_byte(o_data_byte),
        .i_last_of_run(o_last_of_run),
        .o_fail_count(fail_count),
        .o_pending(pending_results)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_CYCLES * 10);
        $display("FAILURE");
        $finish;
    end

    // result port: stretches of different stall patterns, one long hold-off
    initial begin : result_sink
        int mode;
        int stretch_left;
        stretch_left = 0;
        mode = 0;
        @(posedge i_clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (stretch_left == 0) begin
                    mode = $urandom_range(0, 3);
                    stretch_left = $urandom_range(5, 80);
                end
                stretch_left--;
                case (mode)
                    0: i_out_ready <= 1'b1;
                    1: i_out_ready <= ($urandom_range(0, 3) != 0);
                    2: i_out_ready <= (stretch_left % 4 == 0);
                    default: i_out_ready <= 1'($urandom_range(0, 1));
                endcase
                @(posedge i_clk);
            end
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap_len;
        if (burst_left == 0) begin
            gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap_len > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap_len) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end else begin
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] pick_payload_byte();
        logic [BYTE_W-1:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == open_byte || b == close_byte);
        return b;
    endfunction

    function automatic logic [BYTE_W-1:0] pick_noise_byte();
        logic [BYTE_W-1:0] b;
        if ($urandom_range(0, 1) == 0 && close_byte != open_byte)
            return close_byte;
        do
            b = 8'($urandom_range(0, 255));
        while (b == open_byte);
        return b;
    endfunction

    task automatic send_frame(input int len);
        send_byte(open_byte);
        repeat (len) send_byte(pick_payload_byte());
        send_byte(close_byte);
    endtask

    task automatic send_random_traffic(input int budget);
        int goal;
        goal = bytes_sent + budget;
        while (bytes_sent < goal) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: send_frame($urandom_range(1, 6));
                4: begin
                    if ($urandom_range(0, 3) == 0)
                        send_frame($urandom_range(7, FRAME_BUFFER_BYTES - 1));
                    else
                        send_frame($urandom_range(7, 16));
                end
                5: begin
                    send_byte(open_byte);
                    send_byte(close_byte);
                end
                6: begin
                    send_byte(open_byte);
                    repeat ($urandom_range(0, 3)) send_byte(pick_payload_byte());
                    send_byte(open_byte);
                end
                7: repeat ($urandom_range(1, 4)) send_byte(pick_noise_byte());
                8: begin
                    send_byte(open_byte);
                    repeat ($urandom_range(1, 4)) send_byte(pick_payload_byte());
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
                end
                default: begin
                    send_frame($urandom_range(1, 3));
                    send_byte(close_byte);
                end
            endcase
        end
    endtask

    task automatic wait_for_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_markers(input logic [BYTE_W-1:0] s, input logic [BYTE_W-1:0] e);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_START_MARKER;
        i_cfg_data <= s;
        @(posedge i_clk);
        i_cfg_index <= REG_END_MARKER;
        i_cfg_data <= e;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        open_byte = s;
        close_byte = e;
    endtask

    initial begin : stimulus
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
        int guard;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset markers: drops while waiting, empty frame, runs, double starts
        send_byte(close_byte);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(open_byte);
        send_byte(close_byte);
        send_byte(open_byte);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'hAA);
        send_byte(8'h55);
        send_byte(close_byte);
        send_byte(open_byte);
        send_byte(8'h81);
        send_byte(close_byte);
        send_byte(open_byte);
        send_byte(8'h07);
        send_byte(open_byte);
        send_byte(open_byte);
        send_byte(open_byte);
        wait_for_idle();

        // full buffer, then overflow
        write_markers(8'h00, 8'hFF);
        send_frame(FRAME_BUFFER_BYTES - 1);
        send_byte(open_byte);
        repeat (FRAME_BUFFER_BYTES) send_byte(pick_payload_byte());
        send_random_traffic(6);
        wait_for_idle();

        write_markers(8'hFF, 8'h00);
        send_random_traffic(6);
        wait_for_idle();

        // equal markers: the shared byte acts as a start marker
        write_markers(8'h7E, 8'h7E);
        send_random_traffic(6);
        wait_for_idle();

        a = 8'($urandom_range(0, 255));
        do
            b = 8'($urandom_range(0, 255));
        while (b == a);
        write_markers(a, b);
        hold_off_req = 1'b1;
        send_random_traffic(14);
        wait_for_idle();

        write_markers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        send_random_traffic(6);
        wait_for_idle();

        write_markers(START_MARKER_RST, END_MARKER_RST);
        send_random_traffic(6);

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (pending_results != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (FRAME_BUFFER_BYTES + SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
